// ----- hw/rtl/arst_pkg.sv -----
// ---------------------------------------------------------------------------
// arst_pkg
// shared types and codes of the address reader set table
// ---------------------------------------------------------------------------
package arst_pkg;

  localparam int READER_W = 16;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MERGE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } arst_state_t;

endpackage

// ----- hw/rtl/address_reader_set_table.sv -----
// ---------------------------------------------------------------------------
// address_reader_set_table
// maps an address tag to a set of reader ids; one shared compare unit scans
// the entry memory one entry per cycle, then at most one write updates it
// a new item is accepted only once the last one has been scanned and written out,
// held back by the scan loop over the single read port of the entry memory
// reset: clears control, then a clearing pass over every entry
// invalidates each one while in_tready stays low
// ---------------------------------------------------------------------------
module address_reader_set_table import arst_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int READER_COUNT  = 16,
  parameter int TAG_BITS      = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [55:0]         in_tdata,   // address_tag[31:0], reader_id[35:32], reader_mask[51:36]
  input  logic [KIND_W-1:0]   in_tuser,   // kind[2:0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // is_present[0], readers_now[16:1]
  output logic [STATUS_W-1:0] out_tuser   // status[1:0]
);

  localparam int TAG_W = (TAG_BITS < 32) ? TAG_BITS : 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int MEM_W = 1 + TAG_W + READER_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [READER_W-1:0] LEGAL_MASK = (READER_COUNT >= READER_W) ?
    {READER_W{1'b1}} : READER_W'((64'd1 << READER_COUNT) - 64'd1);

  // entry memory: valid, tag, readers
  logic [MEM_W-1:0] mem [TABLE_ENTRIES];
  logic [MEM_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  arst_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [READER_W-1:0] bit_r, bit_nxt;
  logic [READER_W-1:0] merge_r, merge_nxt;

  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r, hit_idx_nxt;
  logic [READER_W-1:0] hit_readers_r, hit_readers_nxt;
  logic                free_r, free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;

  logic                out_tvalid_r, out_tvalid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_present_r, out_present_nxt;
  logic [READER_W-1:0] out_readers_r, out_readers_nxt;

  logic                in_acc;
  logic                out_load;
  logic                upd_we;
  logic [IDX_W-1:0]    upd_idx;
  logic [READER_W-1:0] upd_readers;
  logic [READER_W-1:0] upd_add;
  logic [STATUS_W-1:0] res_status;
  logic                res_present;
  logic [READER_W-1:0] res_readers;

  logic                rd_valid;
  logic [TAG_W-1:0]    rd_tag;
  logic [READER_W-1:0] rd_readers;

  assign rd_valid   = rd_data_r[MEM_W-1];
  assign rd_tag     = rd_data_r[READER_W +: TAG_W];
  assign rd_readers = rd_data_r[READER_W-1:0];

  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_readers_r, out_present_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == CNT_LAST) state_nxt = ST_UPDATE;
      ST_UPDATE: if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[IDX_W-1:0];
    mem_wdata = '0;
    rd_addr   = cnt_r[IDX_W-1:0];
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SCAN: begin
      end
      ST_UPDATE: begin
        out_load  = !out_tvalid_r || out_tready;
        mem_we    = out_load && upd_we;
        mem_waddr = upd_idx;
        mem_wdata = {1'b1, tag_r, upd_readers};
      end
      default: begin
      end
    endcase
  end

  // update decision
  always_comb begin
    upd_we      = 1'b0;
    upd_idx     = hit_idx_r;
    upd_readers = hit_readers_r;
    upd_add     = (kind_r == KIND_ADD) ? bit_r : merge_r;
    res_status  = STATUS_OK;
    res_present = 1'b0;
    res_readers = '0;
    case (kind_r)
      KIND_ADD, KIND_MERGE: begin
        if (hit_r) begin
          upd_we      = 1'b1;
          upd_readers = hit_readers_r | upd_add;
          res_readers = hit_readers_r | upd_add;
        end else if (kind_r == KIND_MERGE && upd_add == '0) begin
          res_status = STATUS_NOT_FOUND;
        end else if (!free_r) begin
          res_status = STATUS_FULL;
        end else begin
          upd_we      = 1'b1;
          upd_idx     = free_idx_r;
          upd_readers = upd_add;
          res_readers = upd_add;
        end
      end
      KIND_REMOVE, KIND_QUERY, KIND_READ: begin
        if (!hit_r) begin
          res_status = STATUS_NOT_FOUND;
        end else if (kind_r == KIND_REMOVE) begin
          upd_we      = 1'b1;
          upd_readers = hit_readers_r & ~bit_r;
          res_readers = hit_readers_r & ~bit_r;
        end else begin
          res_present = (kind_r == KIND_QUERY) && |(hit_readers_r & bit_r);
          res_readers = hit_readers_r;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_nxt         = cnt_r;
    cmp_vld_nxt     = (state_r == ST_SCAN) && (cnt_r != CNT_LAST);
    cmp_idx_nxt     = cnt_r[IDX_W-1:0];
    kind_nxt        = kind_r;
    tag_nxt         = tag_r;
    bit_nxt         = bit_r;
    merge_nxt       = merge_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_readers_nxt = hit_readers_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_present_nxt = out_present_r;
    out_readers_nxt = out_readers_r;

    case (state_r)
      ST_CLEAR, ST_SCAN: cnt_nxt = cnt_r + 1'b1;
      ST_IDLE:           cnt_nxt = '0;
      default:           cnt_nxt = cnt_r;
    endcase

    if (in_acc) begin
      kind_nxt  = in_tuser;
      tag_nxt   = in_tdata[TAG_W-1:0];
      bit_nxt   = (READER_W'(1) << in_tdata[35:32]) & LEGAL_MASK;
      merge_nxt = in_tdata[51:36] & LEGAL_MASK;
      hit_nxt   = 1'b0;
      free_nxt  = 1'b0;
    end

    // shared compare unit, one entry per cycle
    if (cmp_vld_r) begin
      if (rd_valid && rd_tag == tag_r) begin
        hit_nxt         = 1'b1;
        hit_idx_nxt     = cmp_idx_r;
        hit_readers_nxt = rd_readers;
      end
      if (!rd_valid && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp_idx_r;
      end
    end

    if (out_load) begin
      out_tvalid_nxt  = 1'b1;
      out_status_nxt  = res_status;
      out_present_nxt = res_present;
      out_readers_nxt = res_readers;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r     <= cmp_idx_nxt;
    kind_r        <= kind_nxt;
    tag_r         <= tag_nxt;
    bit_r         <= bit_nxt;
    merge_r       <= merge_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_readers_r <= hit_readers_nxt;
    free_idx_r    <= free_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_present_r <= out_present_nxt;
    out_readers_r <= out_readers_nxt;
  end

endmodule
